>>> rtl/qn_pkg.sv
// Shared widths and item types for the quaternion normalize pipeline.
// No dependencies; imported by every module of the block.
package qn_pkg;

  localparam int COMP_W = 16;              // input component width
  localparam int FRAC_W = 14;              // fraction bits of a unit component
  localparam int UNIT_W = FRAC_W + 2;      // output component width
  localparam int LEN_W  = COMP_W + 1;      // root width
  localparam int SQ_W   = 2 * COMP_W - 1;  // one square, at most 2^30
  localparam int SUM_W  = 2 * COMP_W + 1;  // sum of four squares
  localparam int RAD_W  = 2 * LEN_W;       // radicand padded to whole digit pairs
  localparam int REM_W  = LEN_W + 3;       // square root partial remainder
  localparam int QUO_W  = FRAC_W + 1;      // quotient, at most 2^FRAC_W
  localparam int NUM_W  = COMP_W + FRAC_W; // dividend width
  localparam int SQRT_STAGES = LEN_W;
  localparam int DIV_STAGES  = QUO_W;

  localparam logic [QUO_W-1:0] ONE_FIXED = QUO_W'(1) << FRAC_W;

  typedef logic [3:0][COMP_W-1:0] mag_vec_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    mag_vec_t         mag;
    logic [3:0]       neg;
  } sum_item_t;

  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] root;
    mag_vec_t         mag;
    logic [3:0]       neg;
  } root_item_t;

  typedef struct packed {
    logic                  valid;
    logic [3:0][QUO_W-1:0] quo;
    logic [LEN_W-1:0]      root;
    logic [3:0]            neg;
  } quo_item_t;

endpackage

>>> rtl/qn_square_sum.sv
// Absolute values, four squares and their sum over two register stages.
// Depends on qn_pkg.
module qn_square_sum import qn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [3:0][COMP_W-1:0] in_comp,
  output sum_item_t             sum_item
);

  logic                  sq_valid_r;
  logic [3:0][SQ_W-1:0]  sq_r;
  mag_vec_t              mag_r;
  logic [3:0]            neg_r;
  mag_vec_t              mag_nxt;
  logic [3:0]            neg_nxt;
  logic [3:0][SQ_W-1:0]  sq_nxt;
  logic [SUM_W-1:0]      sum_nxt;
  sum_item_t             sum_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg_nxt[i] = in_comp[i][COMP_W-1];
      mag_nxt[i] = neg_nxt[i] ? (~in_comp[i] + COMP_W'(1)) : in_comp[i];
      sq_nxt[i]  = SQ_W'(mag_nxt[i]) * SQ_W'(mag_nxt[i]);
    end
    sum_nxt = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r  <= 1'b0;
      sum_r.valid <= 1'b0;
    end else if (en) begin
      sq_valid_r  <= in_valid;
      sum_r.valid <= sq_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r      <= sq_nxt;
      mag_r     <= mag_nxt;
      neg_r     <= neg_nxt;
      sum_r.sum <= sum_nxt;
      sum_r.mag <= mag_r;
      sum_r.neg <= neg_r;
    end
  end

  assign sum_item = sum_r;

endmodule

>>> rtl/qn_isqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on qn_pkg.
module qn_isqrt import qn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  sum_item_t  sum_item,
  output root_item_t root_item
);

  typedef struct packed {
    logic             valid;
    logic [REM_W-1:0] rem;
    logic [LEN_W-1:0] root;
    logic [RAD_W-1:0] rad;
    mag_vec_t         mag;
    logic [3:0]       neg;
  } sqrt_stage_t;

  sqrt_stage_t stage [0:SQRT_STAGES];

  always_comb begin
    stage[0].valid = sum_item.valid;
    stage[0].rem   = '0;
    stage[0].root  = '0;
    stage[0].rad   = RAD_W'(sum_item.sum);
    stage[0].mag   = sum_item.mag;
    stage[0].neg   = sum_item.neg;
  end

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_step
    sqrt_stage_t      stage_r;
    sqrt_stage_t      stage_nxt;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;

    always_comb begin
      shifted   = {stage[j].rem[REM_W-3:0], stage[j].rad[2*(SQRT_STAGES-1-j) +: 2]};
      trial     = {1'b0, stage[j].root, 2'b01};
      stage_nxt = stage[j];
      if (shifted >= trial) begin
        stage_nxt.rem  = shifted - trial;
        stage_nxt.root = {stage[j].root[LEN_W-2:0], 1'b1};
      end else begin
        stage_nxt.rem  = shifted;
        stage_nxt.root = {stage[j].root[LEN_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r.valid <= 1'b0;
      end else if (en) begin
        stage_r.valid <= stage_nxt.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r.rem  <= stage_nxt.rem;
        stage_r.root <= stage_nxt.root;
        stage_r.rad  <= stage_nxt.rad;
        stage_r.mag  <= stage_nxt.mag;
        stage_r.neg  <= stage_nxt.neg;
      end
    end

    assign stage[j+1] = stage_r;
  end

  always_comb begin
    root_item.valid = stage[SQRT_STAGES].valid;
    root_item.root  = stage[SQRT_STAGES].root;
    root_item.mag   = stage[SQRT_STAGES].mag;
    root_item.neg   = stage[SQRT_STAGES].neg;
  end

endmodule

>>> rtl/qn_divide.sv
// Four-lane pipelined restoring divider: (mag << FRAC_W) / root, one bit per stage.
// Depends on qn_pkg.
module qn_divide import qn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  root_item_t root_item,
  output quo_item_t  quo_item
);

  typedef struct packed {
    logic                  valid;
    logic [3:0][LEN_W-1:0] rem;
    logic [3:0][QUO_W-1:0] quo;
    logic [LEN_W-1:0]      root;
    mag_vec_t              mag;
    logic [3:0]            neg;
  } div_stage_t;

  div_stage_t stage [0:DIV_STAGES];

  // Top dividend bits above the quotient range seed the remainder.
  always_comb begin
    stage[0].valid = root_item.valid;
    for (int i = 0; i < 4; i++) begin
      stage[0].rem[i] = LEN_W'(root_item.mag[i][COMP_W-1:1]);
      stage[0].quo[i] = '0;
    end
    stage[0].root = root_item.root;
    stage[0].mag  = root_item.mag;
    stage[0].neg  = root_item.neg;
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
    div_stage_t            stage_r;
    div_stage_t            stage_nxt;
    logic [3:0][LEN_W:0]   shifted;
    logic [3:0][NUM_W-1:0] num;

    always_comb begin
      stage_nxt = stage[j];
      for (int i = 0; i < 4; i++) begin
        num[i]     = {stage[j].mag[i], FRAC_W'(0)};
        shifted[i] = {stage[j].rem[i], num[i][DIV_STAGES-1-j]};
        if (shifted[i] >= {1'b0, stage[j].root}) begin
          stage_nxt.rem[i] = LEN_W'(shifted[i] - {1'b0, stage[j].root});
          stage_nxt.quo[i] = {stage[j].quo[i][QUO_W-2:0], 1'b1};
        end else begin
          stage_nxt.rem[i] = shifted[i][LEN_W-1:0];
          stage_nxt.quo[i] = {stage[j].quo[i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r.valid <= 1'b0;
      end else if (en) begin
        stage_r.valid <= stage_nxt.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r.rem  <= stage_nxt.rem;
        stage_r.quo  <= stage_nxt.quo;
        stage_r.root <= stage_nxt.root;
        stage_r.mag  <= stage_nxt.mag;
        stage_r.neg  <= stage_nxt.neg;
      end
    end

    assign stage[j+1] = stage_r;
  end

  always_comb begin
    quo_item.valid = stage[DIV_STAGES].valid;
    quo_item.quo   = stage[DIV_STAGES].quo;
    quo_item.root  = stage[DIV_STAGES].root;
    quo_item.neg   = stage[DIV_STAGES].neg;
  end

endmodule

>>> rtl/quaternion_normalize_core.sv
// Quaternion normalize core: squares and root stages, four-lane divider, output register.
// Depends on qn_pkg, qn_square_sum, qn_isqrt and qn_divide.
//
// Takes one quaternion per clock while in_tready is high and returns its unit quaternion
// in signed Q1.14 together with the truncated root of the sum of squares. Squares and the
// sum are registered, then the square root produces one root bit per stage and the
// dividers one quotient bit per stage, followed by the output register. Sustained rate is
// one item per cycle while the output is not stalled. The whole pipeline advances together
// whenever the output register is empty or being taken; in_tready follows that condition.
// A zero quaternion returns zeros with out_tuser set.
module quaternion_normalize_core import qn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // comp_x, comp_y, comp_z, comp_w
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // unit_x, unit_y, unit_z, unit_w, length, zero pad
  output logic        out_tuser   // zero_input
);

  logic                   en;
  logic [3:0][COMP_W-1:0] comp;
  sum_item_t              sum_item;
  root_item_t             root_item;
  quo_item_t              quo_item;

  logic                   out_valid_r;
  logic [3:0][UNIT_W-1:0] unit_r;
  logic [LEN_W-1:0]       length_r;
  logic                   zero_r;
  logic [3:0][UNIT_W-1:0] unit_nxt;
  logic [QUO_W-1:0]       sat;
  logic                   zero_nxt;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign comp      = in_tdata;

  qn_square_sum u_square_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_comp  (comp),
    .sum_item (sum_item)
  );

  qn_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .sum_item  (sum_item),
    .root_item (root_item)
  );

  qn_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .root_item (root_item),
    .quo_item  (quo_item)
  );

  // Clamp, restore sign, force zero for a zero quaternion.
  always_comb begin
    zero_nxt = (quo_item.root == '0);
    sat      = '0;
    for (int i = 0; i < 4; i++) begin
      sat = (quo_item.quo[i] > ONE_FIXED) ? ONE_FIXED : quo_item.quo[i];
      if (zero_nxt) begin
        unit_nxt[i] = '0;
      end else if (quo_item.neg[i]) begin
        unit_nxt[i] = ~UNIT_W'(sat) + UNIT_W'(1);
      end else begin
        unit_nxt[i] = UNIT_W'(sat);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= quo_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r   <= unit_nxt;
      length_r <= quo_item.root;
      zero_r   <= zero_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, length_r, unit_r};
  assign out_tuser  = zero_r;

  a_zero_all_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && zero_r |-> (unit_r == '0) && (length_r == '0))
    else $error("zero flag with nonzero outputs");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !zero_r |->
      ($signed(unit_r[0]) <= 16384) && ($signed(unit_r[0]) >= -16384) &&
      ($signed(unit_r[3]) <= 16384) && ($signed(unit_r[3]) >= -16384))
    else $error("unit component out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(length_r) && $stable(unit_r))
    else $error("output register changed while stalled");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_valid_r || out_tready))
    else $error("input ready out of step with output stage");

endmodule
